### rtl/srtf_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the srtf process scheduler
// no dependencies

package srtf_pkg;

  localparam int NUM_SLOTS  = 16;
  localparam int BURST_BITS = 16;
  localparam int SLOT_W     = (NUM_SLOTS > 2) ? $clog2(NUM_SLOTS) : 1;

  localparam logic MODE_TICK    = 1'b0;
  localparam logic MODE_ARRIVAL = 1'b1;

  typedef enum logic [1:0] {
    EV_IDLE    = 2'd0,
    EV_RAN     = 2'd1,
    EV_DONE    = 2'd2,
    EV_ARRIVAL = 2'd3
  } srtf_event_t;

  // best-so-far candidate handed from cell to cell during a scan
  typedef struct packed {
    logic                  found;
    logic [BURST_BITS-1:0] rem;
    logic [SLOT_W-1:0]     idx;
    logic [31:0]           stamp;
    logic [BURST_BITS-1:0] burst;
  } srtf_tok_t;

  // update broadcast from the sequencer to every cell
  typedef struct packed {
    logic                  wr_en;
    logic                  run_en;
    logic [SLOT_W-1:0]     idx;
    logic [BURST_BITS-1:0] burst;
    logic [31:0]           stamp;
  } srtf_cmd_t;

endpackage

### rtl/srtf_process_scheduler.sv
`timescale 1ns / 1ps
// top level of the shortest-remaining-time-first scheduler: sequencer, cell chain
// depends on srtf_pkg and srtf_cell

// Preemptive shortest-remaining-time-first scheduler over NUM_SLOTS job slots.
// Each slot lives in a cell of a chain; a tick request is resolved by letting a
// best-so-far candidate ripple through the chain, one registered cell per cycle.
// A tick passes an accept step, scan steps until the candidate leaves the last
// cell, a step to form the turnaround and a commit step; an arrival request goes
// from its accept step straight to the commit step. One request is in work at a
// time; results sit in an output register, so a new request is taken while the
// previous result still waits, and the commit step holds only while that register
// is full and stalled. Every request yields exactly one result. Slot valid marks
// clear at reset; the per-slot times and stamps need no clearing since they are
// read only once valid.

module srtf_process_scheduler
  import srtf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_mode,
  input  logic [3:0]  in_slot,
  input  logic [15:0] in_burst,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_event_res,
  output logic [3:0]  out_job_slot,
  output logic [31:0] out_finish_time,
  output logic [31:0] out_turnaround,
  output logic [31:0] out_waiting,
  output logic        out_arrival_ok
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_CALC   = 4'b0100,
    ST_FINISH = 4'b1000
  } srtf_state_t;

  srtf_state_t state_r, state_nxt;

  // request held while it is in work
  logic                  mode_r;
  logic [3:0]            slot_r;
  logic [BURST_BITS-1:0] burst_r;
  logic [BURST_BITS+15:0] burst_ext;

  logic [SLOT_W-1:0] cnt_r;
  logic [31:0]       time_r;
  logic [31:0]       ta_r;

  // output register
  logic        out_valid_r;
  srtf_event_t ev_r;
  logic [3:0]  job_slot_r;
  logic [31:0] fin_r;
  logic [31:0] ta_out_r;
  logic [31:0] wt_r;
  logic        ok_r;

  srtf_tok_t             tok_chain [0:NUM_SLOTS];
  srtf_tok_t             best;
  srtf_cmd_t             cmd;
  logic [NUM_SLOTS-1:0]  valid_vec;

  logic                  in_take;
  logic                  commit;
  logic                  arr_ok;
  logic                  in_range;
  logic [SLOT_W+3:0]     slot_ext;
  logic [SLOT_W-1:0]     slot_idx;
  logic [SLOT_W+3:0]     best_ext;
  logic                  done;

  // ---------------------------------------------------------------- cell chain
  assign tok_chain[0] = '0;

  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
    srtf_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (SLOT_W'(i)),
      .tok_i    (tok_chain[i]),
      .cmd      (cmd),
      .tok_o    (tok_chain[i+1]),
      .valid_o  (valid_vec[i])
    );
  end

  assign best = tok_chain[NUM_SLOTS];

  // ---------------------------------------------------------------- decode
  assign in_stall = (state_r != ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  // commit only when the output register can take the result
  assign commit   = (state_r == ST_FINISH) && (!out_valid_r || !out_stall);

  assign burst_ext = {BURST_BITS'(0), in_burst};
  assign slot_ext  = {SLOT_W'(0), slot_r};
  assign slot_idx  = slot_ext[SLOT_W-1:0];
  assign in_range  = (32'(slot_r) < NUM_SLOTS);
  // busy slot, slot past the table and zero burst are all rejected
  assign arr_ok    = in_range && !valid_vec[slot_idx] && (burst_r != '0);

  assign best_ext = {4'b0, best.idx};
  assign done     = best.found && (best.rem == BURST_BITS'(1));

  always_comb begin
    cmd        = '0;
    cmd.burst  = burst_r;
    cmd.stamp  = time_r;
    cmd.idx    = (mode_r == MODE_ARRIVAL) ? slot_idx : best.idx;
    cmd.wr_en  = commit && (mode_r == MODE_ARRIVAL) && arr_ok;
    cmd.run_en = commit && (mode_r == MODE_TICK) && best.found;
  end

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          // a chain of two or more cells always needs the scan state
          state_nxt = (in_mode == MODE_ARRIVAL) ? ST_FINISH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        // leave the scan once the candidate has passed through every cell of the chain
        if (cnt_r == SLOT_W'(NUM_SLOTS - 2)) begin
          state_nxt = ST_CALC;
        end
      end
      ST_CALC: begin
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (commit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      time_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_SCAN) begin
        cnt_r <= cnt_r + SLOT_W'(1);
      end else begin
        cnt_r <= '0;
      end
      // time advances on every tick, idle or not
      if (commit && (mode_r == MODE_TICK)) begin
        time_r <= time_r + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      mode_r  <= in_mode;
      slot_r  <= in_slot;
      burst_r <= burst_ext[BURST_BITS-1:0];
    end
    // turnaround is taken against the time after this tick
    if (state_r == ST_CALC) begin
      ta_r <= time_r - best.stamp + 32'd1;
    end
  end

  // ---------------------------------------------------------------- result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      if (mode_r == MODE_ARRIVAL) begin
        ev_r       <= EV_ARRIVAL;
        job_slot_r <= slot_r;
        fin_r      <= '0;
        ta_out_r   <= '0;
        wt_r       <= '0;
        ok_r       <= arr_ok;
      end else if (!best.found) begin
        ev_r       <= EV_IDLE;
        job_slot_r <= '0;
        fin_r      <= '0;
        ta_out_r   <= '0;
        wt_r       <= '0;
        ok_r       <= 1'b0;
      end else if (done) begin
        ev_r       <= EV_DONE;
        job_slot_r <= best_ext[3:0];
        fin_r      <= time_r + 32'd1;
        ta_out_r   <= ta_r;
        wt_r       <= ta_r - 32'(best.burst);
        ok_r       <= 1'b0;
      end else begin
        ev_r       <= EV_RAN;
        job_slot_r <= best_ext[3:0];
        fin_r      <= '0;
        ta_out_r   <= '0;
        wt_r       <= '0;
        ok_r       <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_event_res   = ev_r;
  assign out_job_slot    = job_slot_r;
  assign out_finish_time = fin_r;
  assign out_turnaround  = ta_out_r;
  assign out_waiting     = wt_r;
  assign out_arrival_ok  = ok_r;

endmodule

### rtl/srtf_cell.sv
`timescale 1ns / 1ps
// one job slot of the scheduler chain: slot state plus one scan stage
// depends on srtf_pkg

module srtf_cell
  import srtf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [SLOT_W-1:0] cell_idx,
  input  srtf_tok_t         tok_i,
  input  srtf_cmd_t         cmd,
  output srtf_tok_t         tok_o,
  output logic              valid_o
);

  logic                  valid_r;
  logic [BURST_BITS-1:0] rem_r;
  logic [BURST_BITS-1:0] orig_r;
  logic [31:0]           stamp_r;
  srtf_tok_t             tok_r;
  srtf_tok_t             tok_nxt;
  logic                  sel;
  logic                  hit;

  assign sel = (cmd.idx == cell_idx);
  // strict less-than keeps the earlier (lower) slot on a tie
  assign hit = valid_r && (!tok_i.found || (rem_r < tok_i.rem));

  always_comb begin
    tok_nxt = tok_i;
    if (hit) begin
      tok_nxt.found = 1'b1;
      tok_nxt.rem   = rem_r;
      tok_nxt.idx   = cell_idx;
      tok_nxt.stamp = stamp_r;
      tok_nxt.burst = orig_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (cmd.wr_en && sel) begin
      valid_r <= 1'b1;
    end else if (cmd.run_en && sel && (rem_r == BURST_BITS'(1))) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    tok_r <= tok_nxt;
    if (cmd.wr_en && sel) begin
      rem_r   <= cmd.burst;
      orig_r  <= cmd.burst;
      stamp_r <= cmd.stamp;
    end else if (cmd.run_en && sel) begin
      rem_r <= rem_r - BURST_BITS'(1);
    end
  end

  assign tok_o   = tok_r;
  assign valid_o = valid_r;

endmodule

### rtl/srtf_chk.sv
`timescale 1ns / 1ps
// port-level checks for the srtf process scheduler, bound to the top level
// depends on srtf_pkg and srtf_process_scheduler

module srtf_chk
  import srtf_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_event_res,
  input logic [3:0]  out_job_slot,
  input logic [31:0] out_finish_time,
  input logic [31:0] out_turnaround,
  input logic [31:0] out_waiting,
  input logic        out_arrival_ok
);

  // a taken request holds off the next one
  a_take_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after a request was taken");

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_event_res) && $stable(out_job_slot))
    else $error("stalled result changed");

  // only an arrival can report a stored job
  a_ok_arrival: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_res != EV_ARRIVAL) |-> !out_arrival_ok)
    else $error("arrival_ok set on a tick result");

  // completion figures are zero unless a job completed
  a_zero_times: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_res != EV_DONE) |->
      (out_finish_time == 32'd0) && (out_turnaround == 32'd0) && (out_waiting == 32'd0))
    else $error("completion fields set on a non-completion result");

  // an idle tick names slot zero
  a_idle_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_res == EV_IDLE) |-> (out_job_slot == 4'd0))
    else $error("idle tick reports a slot");

endmodule

bind srtf_process_scheduler srtf_chk u_srtf_chk (.*);
